FILE: src/tpc_huffman_word_decoder_top_assert.svh
// assertion macros for the readout word decoder
`ifndef TPC_HUFFMAN_WORD_DECODER_TOP_ASSERT_SVH
`define TPC_HUFFMAN_WORD_DECODER_TOP_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define THWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define THWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/thwd_pkg.sv
// types, constants and helper functions shared by the readout word decoder
package thwd_pkg;

    localparam int HUF_BITS    = 14;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] TAG_HDR = 4'h4;
    localparam logic [3:0] TAG_RAW = 4'h0;
    localparam logic [3:0] TAG_END = 4'h5;
    localparam logic [1:0] TAG_HUF = 2'b10;

    localparam logic [1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [1:0] KIND_MATCH    = 2'd1;
    localparam logic [1:0] KIND_MISMATCH = 2'd2;

    localparam logic [15:0] LONG_CODE_DELTA = 16'd4096;

    typedef logic [3:0] t_pos;

    typedef enum logic [4:0] {
        OP_NOP = 5'b00001,
        OP_HDR = 5'b00010,
        OP_RAW = 5'b00100,
        OP_HUF = 5'b01000,
        OP_END = 5'b10000
    } t_op;

    typedef struct packed {
        logic [15:0] word;
        logic        block_end;
    } t_in;

    typedef struct packed {
        logic [5:0]  channel;
        logic [15:0] sample;
        logic [1:0]  kind;
        logic        code_error;
        logic        last;
    } t_out;

    typedef struct packed {
        t_op                 op;
        logic [HUF_BITS-1:0] bits;
        logic                block_end;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    // index of the lowest set bit, zero when none
    function automatic t_pos lowest_pos(input logic [HUF_BITS-1:0] v);
        t_pos p;
        p = '0;
        for (int i = HUF_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                p = t_pos'(i);
            end
        end
        return p;
    endfunction

    // difference for a code with the given count of leading zeros
    function automatic logic [16:0] code_delta(input t_pos zeros);
        logic [16:0] r;
        case (zeros)
            4'd0:    r = {1'b0, 16'h0000};
            4'd1:    r = {1'b0, 16'hFFFF};
            4'd2:    r = {1'b0, 16'h0001};
            4'd3:    r = {1'b0, 16'hFFFE};
            4'd4:    r = {1'b0, 16'h0002};
            4'd5:    r = {1'b0, 16'hFFFD};
            4'd6:    r = {1'b0, 16'h0003};
            default: r = {1'b1, LONG_CODE_DELTA};
        endcase
        return r;
    endfunction

endpackage

FILE: src/thwd_front.sv
// front end: accepts readout words and classifies them for the queue
module thwd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  thwd_pkg::t_in    i_data,
    input  logic             i_queue_full,
    output logic             o_push,
    output thwd_pkg::t_entry o_entry
);

    thwd_pkg::t_op op;
    logic [3:0]    tag;

    assign tag = i_data.word[15:12];

    always_comb begin
        if (tag == thwd_pkg::TAG_HDR) begin
            op = thwd_pkg::OP_HDR;
        end else if (tag == thwd_pkg::TAG_RAW) begin
            op = thwd_pkg::OP_RAW;
        end else if (i_data.word[15:14] == thwd_pkg::TAG_HUF) begin
            op = (i_data.word[thwd_pkg::HUF_BITS-1:0] != '0) ? thwd_pkg::OP_HUF
                                                            : thwd_pkg::OP_NOP;
        end else if (tag == thwd_pkg::TAG_END) begin
            op = thwd_pkg::OP_END;
        end else begin
            op = thwd_pkg::OP_NOP;
        end
    end

    assign o_ready         = !i_queue_full;
    assign o_push          = i_valid && !i_queue_full;
    assign o_entry.op        = op;
    assign o_entry.bits      = i_data.word[thwd_pkg::HUF_BITS-1:0];
    assign o_entry.block_end = i_data.block_end;

    `include "tpc_huffman_word_decoder_top_assert.svh"

    `THWD_ASSERT_NOW(a_push_only_when_room, i_clk, i_rst_n, o_push, !i_queue_full, "push into full queue")
    `THWD_ASSERT_NOW(a_empty_huf_dropped, i_clk, i_rst_n, o_push && (o_entry.op == thwd_pkg::OP_HUF), o_entry.bits != '0, "empty huffman word queued as work")

endmodule

FILE: src/thwd_queue.sv
// short queue of classified transactions between front and back end
module thwd_queue #(
    parameter int Depth = thwd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  thwd_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output thwd_pkg::t_head  o_head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    thwd_pkg::t_entry r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count, n_count;
    logic             do_push, do_pop;

    assign o_full       = (r_count == CntW'(Depth));
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: src/thwd_back.sv
// back end: executes queued transactions and drives the result register
module thwd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  thwd_pkg::t_head i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output thwd_pkg::t_out  o_data
);

    logic                          r_valid, n_valid;
    thwd_pkg::t_out                r_data, n_data;
    logic [5:0]                    r_ch, n_ch;
    logic [15:0]                   r_ls, n_ls;
    logic                          r_active, n_active;
    logic [thwd_pkg::HUF_BITS-1:0] r_rem, n_rem;

    logic                          out_free;
    logic [thwd_pkg::HUF_BITS-1:0] cur, low_bit, rest;
    thwd_pkg::t_pos                p, q, zeros;
    logic                          huf_last;
    logic [16:0]                   delta;
    logic [15:0]                   sum;
    thwd_pkg::t_entry              ent;

    assign ent      = i_head.entry;
    assign out_free = !r_valid || i_ready;
    assign cur      = r_active ? r_rem : ent.bits;
    assign low_bit  = cur & (~cur + 1'b1);
    assign rest     = cur & ~low_bit;
    assign huf_last = (rest == '0);
    assign p        = thwd_pkg::lowest_pos(cur);
    assign q        = thwd_pkg::lowest_pos(rest);
    assign zeros    = huf_last ? thwd_pkg::t_pos'(thwd_pkg::HUF_BITS - 1) - p : q - p - 1'b1;
    assign delta    = thwd_pkg::code_delta(zeros);
    assign sum      = r_ls + delta[15:0];

    always_comb begin
        n_valid  = r_valid && !i_ready;
        n_data   = r_data;
        n_ch     = r_ch;
        n_ls     = r_ls;
        n_active = r_active;
        n_rem    = r_rem;
        o_pop    = 1'b0;
        if (i_head.valid) begin
            unique case (ent.op)
                thwd_pkg::OP_NOP: begin
                    o_pop = 1'b1;
                end
                thwd_pkg::OP_HDR: begin
                    o_pop = 1'b1;
                    n_ch  = ent.bits[5:0];
                    n_ls  = '0;
                end
                thwd_pkg::OP_RAW: begin
                    if (out_free) begin
                        o_pop             = 1'b1;
                        n_ls              = {4'b0, ent.bits[11:0]};
                        n_valid           = 1'b1;
                        n_data.channel    = r_ch;
                        n_data.sample     = {4'b0, ent.bits[11:0]};
                        n_data.kind       = thwd_pkg::KIND_SAMPLE;
                        n_data.code_error = 1'b0;
                        n_data.last       = 1'b1;
                    end
                end
                thwd_pkg::OP_HUF: begin
                    if (out_free) begin
                        n_ls              = sum;
                        n_valid           = 1'b1;
                        n_data.channel    = r_ch;
                        n_data.sample     = sum;
                        n_data.kind       = thwd_pkg::KIND_SAMPLE;
                        n_data.code_error = delta[16];
                        n_data.last       = huf_last;
                        n_rem             = rest;
                        n_active          = !huf_last;
                        o_pop             = huf_last;
                    end
                end
                thwd_pkg::OP_END: begin
                    if (out_free) begin
                        o_pop             = 1'b1;
                        n_valid           = 1'b1;
                        n_data.channel    = r_ch;
                        n_data.sample     = '0;
                        n_data.kind       = (ent.bits[5:0] == r_ch) ? thwd_pkg::KIND_MATCH
                                                                    : thwd_pkg::KIND_MISMATCH;
                        n_data.code_error = 1'b0;
                        n_data.last       = 1'b1;
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
            if (o_pop && ent.block_end) begin
                n_ch = '0;
                n_ls = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_ch     <= '0;
            r_ls     <= '0;
            r_active <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_ch     <= n_ch;
            r_ls     <= n_ls;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_rem  <= n_rem;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    `include "tpc_huffman_word_decoder_top_assert.svh"

    `THWD_ASSERT_NOW(a_active_has_head, i_clk, i_rst_n, r_active, i_head.valid && (ent.op == thwd_pkg::OP_HUF), "huffman scan without queued word")
    `THWD_ASSERT_NOW(a_marker_is_last, i_clk, i_rst_n, r_valid && (r_data.kind != thwd_pkg::KIND_SAMPLE), r_data.last && (r_data.sample == '0), "ending marker not final result")
    `THWD_ASSERT_NEXT(a_scan_ends_on_pop, i_clk, i_rst_n, o_pop && (ent.op == thwd_pkg::OP_HUF), !r_active, "scan still active after pop")

endmodule

FILE: src/tpc_huffman_word_decoder_top.sv
// Readout word decoder for a delta-compressed ADC stream. A new word is taken every
// cycle while the internal queue (Depth entries, default 4) has room. Headers and ignored
// words yield no result; raw ADC and ending words yield one result each; a Huffman word
// with n codes yields n results, one sample per cycle while the output register is free,
// so the sustained rate is set by the back-end scan and by how fast results are taken
// from the output register. When idle, an accepted word is first written into the queue
// and its first result is then registered in the output register.
module tpc_huffman_word_decoder_top #(
    parameter int Depth = thwd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  thwd_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output thwd_pkg::t_out o_data
);

    logic             queue_full;
    logic             push;
    logic             pop;
    thwd_pkg::t_entry entry;
    thwd_pkg::t_head  head;

    thwd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data       (i_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_entry      (entry)
    );

    thwd_queue #(
        .Depth (Depth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    thwd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

FILE: test/tb_tpc_huffman_word_decoder_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the readout word decoder with random handshakes
module tb_tpc_huffman_word_decoder_top;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           o_ready;
    thwd_pkg::t_in  i_data  = '0;
    logic           o_valid;
    logic           i_ready = 1'b0;
    thwd_pkg::t_out o_data;

    thwd_pkg::t_in  readout_backlog[$];
    thwd_pkg::t_out pending_results[$];
    logic [5:0]     model_channel = '0;
    logic [15:0]    model_sample  = '0;
    logic           steady        = 1'b0;
    int             mismatches    = 0;
    int             quiet_cycles  = 0;

    tpc_huffman_word_decoder_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic decode_readout_word(input thwd_pkg::t_in it);
        logic [15:0]    diffs[thwd_pkg::HUF_BITS];
        logic           errs[thwd_pkg::HUF_BITS];
        int             cnt;
        int             zeros;
        thwd_pkg::t_out r;
        cnt   = 0;
        zeros = 0;
        r = '0;
        r.channel = model_channel;
        r.kind    = thwd_pkg::KIND_SAMPLE;
        if (it.word[15:12] == thwd_pkg::TAG_HDR) begin
            model_channel = it.word[5:0];
            model_sample  = '0;
        end else if (it.word[15:12] == thwd_pkg::TAG_RAW) begin
            model_sample = {4'h0, it.word[11:0]};
            r.sample = model_sample;
            r.last   = 1'b1;
            pending_results.push_back(r);
        end else if (it.word[15:14] == thwd_pkg::TAG_HUF) begin
            for (int b = thwd_pkg::HUF_BITS - 1; b >= 0; b--) begin
                if (it.word[b]) begin
                    errs[cnt] = (zeros > 6);
                    if (zeros > 6) begin
                        diffs[cnt] = thwd_pkg::LONG_CODE_DELTA;
                    end else if (zeros % 2 == 0) begin
                        diffs[cnt] = 16'(zeros / 2);
                    end else begin
                        diffs[cnt] = 16'(-((zeros + 1) / 2));
                    end
                    cnt++;
                    zeros = 0;
                end else begin
                    zeros++;
                end
            end
            // lowest code is applied first
            for (int k = cnt - 1; k >= 0; k--) begin
                model_sample = model_sample + diffs[k];
                r.sample     = model_sample;
                r.code_error = errs[k];
                r.last       = (k == 0);
                pending_results.push_back(r);
            end
        end else if (it.word[15:12] == thwd_pkg::TAG_END) begin
            r.kind = (it.word[5:0] == model_channel) ? thwd_pkg::KIND_MATCH
                                                     : thwd_pkg::KIND_MISMATCH;
            r.last = 1'b1;
            pending_results.push_back(r);
        end
        if (it.block_end) begin
            model_channel = '0;
            model_sample  = '0;
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input thwd_pkg::t_out got);
        thwd_pkg::t_out want;
        if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t unexpected result: expected none, actual %h", $time, got);
        end else begin
            want = pending_results.pop_front();
            compare_field("channel", want.channel, got.channel);
            compare_field("sample", want.sample, got.sample);
            compare_field("kind", want.kind, got.kind);
            compare_field("code_error", want.code_error, got.code_error);
            compare_field("last", want.last, got.last);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) begin
                decode_readout_word(i_data);
            end
            if (readout_backlog.size() > 0 && (steady || $urandom_range(99) >= 32)) begin
                i_valid <= 1'b1;
                i_data  <= readout_backlog.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                check_result(o_data);
            end
            i_ready <= steady || ($urandom_range(99) >= 32);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_item(input logic [15:0] w, input logic be);
        thwd_pkg::t_in it;
        it.word      = w;
        it.block_end = be;
        readout_backlog.push_back(it);
    endtask

    task automatic wait_idle(input bit results_too);
        while (readout_backlog.size() > 0 || i_valid
               || (results_too && pending_results.size() > 0))
            @(negedge i_clk);
    endtask

    task automatic queue_random(input int target);
        int          made;
        int          n;
        logic [5:0]  ch;
        logic [13:0] code;
        made = 0;
        while (made < target) begin
            if ($urandom_range(99) < 15) begin
                push_item(16'($urandom), $urandom_range(3) == 0);
                made += 1;
            end else begin
                // well-formed channel block: header, data words, ending word
                ch = 6'($urandom);
                n  = $urandom_range(6, 1);
                push_item({thwd_pkg::TAG_HDR, 6'($urandom), ch}, $urandom_range(24) == 0);
                for (int k = 0; k < n; k++) begin
                    code = 14'($urandom);
                    if ($urandom_range(2) == 0)
                        code = code & 14'($urandom) & 14'($urandom);
                    if ($urandom_range(2) == 0)
                        push_item({thwd_pkg::TAG_RAW, 12'($urandom)}, $urandom_range(14) == 0);
                    else
                        push_item({thwd_pkg::TAG_HUF, code}, $urandom_range(14) == 0);
                end
                push_item({thwd_pkg::TAG_END, 6'($urandom),
                           ($urandom_range(4) == 0) ? 6'($urandom) : ch},
                          $urandom_range(1) == 1);
                made += n + 2;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_item({thwd_pkg::TAG_HDR, 12'h03F}, 1'b0);
        push_item({thwd_pkg::TAG_RAW, 12'hFFF}, 1'b0);
        push_item({thwd_pkg::TAG_END, 12'h03F}, 1'b0);
        push_item({thwd_pkg::TAG_END, 12'h000}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h0001}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h3FFF}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h1000}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h0800}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h0400}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h0200}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h0100}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h0080}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h0040}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h2A50}, 1'b0);
        push_item({thwd_pkg::TAG_HDR, 12'hFC5}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h1000}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h0080}, 1'b0);
        push_item({thwd_pkg::TAG_HUF, 14'h0000}, 1'b0);
        push_item({thwd_pkg::TAG_END, 12'hFC5}, 1'b1);
        push_item({thwd_pkg::TAG_END, 12'h000}, 1'b0);
        push_item(16'h3FFF, 1'b0);
        push_item(16'hC000, 1'b1);
        push_item(16'hFFFF, 1'b0);
        push_item({thwd_pkg::TAG_RAW, 12'h000}, 1'b1);

        // sender holds off until every result is back
        wait_idle(1'b1);
        queue_random(115);
        wait_idle(1'b0);
        steady = 1'b1;
        queue_random(100);
        wait_idle(1'b0);
        steady = 1'b0;
        queue_random(115);
        wait_idle(1'b1);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: tpc_huffman_word_decoder_top.f
+incdir+src
src/thwd_pkg.sv
src/thwd_front.sv
src/thwd_queue.sv
src/thwd_back.sv
src/tpc_huffman_word_decoder_top.sv
test/tb_tpc_huffman_word_decoder_top.sv
